// File: design/ubfs_pkg.sv
package ubfs_pkg;

  localparam int ImageIndexBitsDefault = 24;
  localparam int ChunkBytesDefault = 256;

  localparam logic [7:0] AckByte = 8'h79;
  localparam logic [7:0] CmdSync = 8'h7F;
  localparam logic [7:0] CmdErase = 8'h43;
  localparam logic [7:0] CmdGlobal = 8'hFF;
  localparam logic [7:0] CmdUnprot = 8'h92;
  localparam logic [7:0] CmdWrite = 8'h31;
  localparam logic [7:0] CmdGo = 8'h21;

  localparam logic [2:0] RegImageLength = 3'd0;
  localparam logic [2:0] RegBaseAddress = 3'd1;
  localparam logic [2:0] RegTimeout = 3'd2;
  localparam logic [2:0] RegHold = 3'd3;
  localparam logic [2:0] RegSettle = 3'd4;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_RX    = 2'd1,
    OP_TICK  = 2'd2,
    OP_IMAGE = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

endpackage

// File: design/uart_bootloader_flash_sequencer.sv
// Programming sequencer for a serial bootloader target. Each event beat on the slave side
// (tuser selects start, received byte, tick or image byte; tdata carries the byte) produces
// one to five result beats on the master side, the last flagged by tlast. A two-entry queue
// decouples intake from the sequencer. The sequencer takes the next event at the same edge
// that the final result beat of the current one is accepted. From an empty queue an event
// beat is first written into the queue, then loaded into the sequencer registers, and only
// then is its first result beat presented. Result tdata from bit 0: tx_byte, power_on,
// tx_forced_low, need_image, image_index, busy_res, done_res, success, zero padded to whole
// bytes; tuser: tx_valid. Config writes take effect at once and belong between runs.
module uart_bootloader_flash_sequencer
  import ubfs_pkg::*;
#(
  parameter int IMAGE_INDEX_BITS = ImageIndexBitsDefault,
  parameter int CHUNK_BYTES = ChunkBytesDefault
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [2:0]                                    cfg_index,
  input  logic [31:0]                                   cfg_data,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  input  logic [7:0]                                    s_axis_tdata, // data_byte
  input  logic [1:0]                                    s_axis_tuser, // operation
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // tx_byte, power_on, tx_forced_low, need_image, image_index, busy_res, done_res, success
  output logic [((IMAGE_INDEX_BITS + 21) / 8) * 8 - 1:0] m_axis_tdata,
  output logic [0:0]                                    m_axis_tuser, // tx_valid
  output logic                                          m_axis_tlast
);

  item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item.op = op_t'(s_axis_tuser);
  assign in_item.data = s_axis_tdata;

  ubfs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  ubfs_back #(.IMAGE_INDEX_BITS(IMAGE_INDEX_BITS), .CHUNK_BYTES(CHUNK_BYTES)) u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast)
  );

endmodule

// File: design/ubfs_front.sv
module ubfs_front
  import ubfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  output logic       q_valid,
  input  logic       q_ready,
  output item_t      q_item
);

  item_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_valid && q_ready) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

// File: design/ubfs_back.sv
module ubfs_back
  import ubfs_pkg::*;
#(
  parameter int IMAGE_INDEX_BITS = ImageIndexBitsDefault,
  parameter int CHUNK_BYTES = ChunkBytesDefault
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [2:0]                                    cfg_index,
  input  logic [31:0]                                   cfg_data,
  input  logic                                          q_valid,
  output logic                                          q_ready,
  input  item_t                                         q_item,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [((IMAGE_INDEX_BITS + 21) / 8) * 8 - 1:0] out_data,
  output logic [0:0]                                    out_user,
  output logic                                          out_last
);

  typedef enum logic [13:0] {
    P_IDLE    = 14'b00000000000001,
    P_HOLD    = 14'b00000000000010,
    P_SETTLE  = 14'b00000000000100,
    P_SYNC    = 14'b00000000001000,
    P_ERASE   = 14'b00000000010000,
    P_GLOBAL  = 14'b00000000100000,
    P_UNPROT1 = 14'b00000001000000,
    P_UNPROT2 = 14'b00000010000000,
    P_WCMD    = 14'b00000100000000,
    P_WADDR   = 14'b00001000000000,
    P_FEED    = 14'b00010000000000,
    P_WDATA   = 14'b00100000000000,
    P_GOCMD   = 14'b01000000000000,
    P_GOADDR  = 14'b10000000000000
  } phase_t;

  localparam int DataBits = ((IMAGE_INDEX_BITS + 21) / 8) * 8;
  localparam logic [24:0] MaxLen = 25'h1000000;
  localparam logic [24:0] ChunkLen = 25'(CHUNK_BYTES);

  logic [24:0] image_length;
  logic [31:0] base_address;
  logic [15:0] response_timeout_ticks, reset_hold_ticks, reset_settle_ticks;

  phase_t phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [24:0] bytes_left, bytes_left_next;
  logic [31:0] write_address, write_address_next;
  logic [IMAGE_INDEX_BITS-1:0] image_offset, image_offset_next;
  logic [7:0] chunk_last_index, chunk_last_index_next;
  logic [8:0] chunk_position, chunk_position_next;
  logic [7:0] running_checksum, running_checksum_next;
  logic success_flag, success_flag_next, second_reset, second_reset_next;
  logic unprotect_path, unprotect_path_next;

  logic [7:0] bytes_q [5];
  logic [7:0] bytes_n [5];
  logic [2:0] nbytes, nbytes_n, sent;
  logic want_q, want_n, done_q, done_n;
  logic emitting;

  logic waiting;
  logic [15:0] tick_inc;
  logic [24:0] len;
  logic [24:0] bl_dec;
  logic [8:0] pos_inc;
  logic [7:0] sum_new;
  logic [7:0] db;
  logic [7:0] ab;
  logic [31:0] aa;
  logic [2:0] nres;
  logic fin;

  assign waiting = (phase == P_SYNC) || (phase == P_ERASE) || (phase == P_GLOBAL) ||
                   (phase == P_UNPROT1) || (phase == P_UNPROT2) || (phase == P_WCMD) ||
                   (phase == P_WADDR) || (phase == P_WDATA) || (phase == P_GOCMD) ||
                   (phase == P_GOADDR);

  // next event may load while the final beat of the current one is taken
  assign q_ready = !emitting || (out_ready && fin);

  always_comb begin
    phase_next = phase;
    tick_count_next = tick_count;
    bytes_left_next = bytes_left;
    write_address_next = write_address;
    image_offset_next = image_offset;
    chunk_last_index_next = chunk_last_index;
    chunk_position_next = chunk_position;
    running_checksum_next = running_checksum;
    success_flag_next = success_flag;
    second_reset_next = second_reset;
    unprotect_path_next = unprotect_path;
    nbytes_n = 3'd0;
    want_n = 1'b0;
    done_n = 1'b0;
    for (int i = 0; i < 5; i++) begin
      bytes_n[i] = 8'h00;
    end
    db = q_item.data;
    tick_inc = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
    len = (bytes_left >= ChunkLen) ? ChunkLen : bytes_left;
    bl_dec = (bytes_left != 25'd0) ? bytes_left - 25'd1 : bytes_left;
    pos_inc = chunk_position + 9'd1;
    sum_new = running_checksum ^ db;
    aa = (phase == P_GOCMD) ? base_address : write_address;
    ab = aa[31:24] ^ aa[23:16] ^ aa[15:8] ^ aa[7:0];

    unique case (q_item.op)
      OP_START: begin
        if (phase == P_IDLE) begin
          bytes_left_next = (image_length > MaxLen) ? MaxLen : image_length;
          write_address_next = base_address;
          image_offset_next = '0;
          chunk_last_index_next = 8'd0;
          chunk_position_next = 9'd0;
          running_checksum_next = 8'd0;
          success_flag_next = 1'b0;
          second_reset_next = 1'b0;
          unprotect_path_next = 1'b0;
          phase_next = P_HOLD;
          tick_count_next = 16'd0;
        end
      end
      OP_RX, OP_TICK: begin
        if (q_item.op == OP_TICK) begin
          tick_count_next = tick_inc;
        end
        if (q_item.op == OP_TICK && phase == P_HOLD) begin
          if (tick_inc >= reset_hold_ticks) begin
            phase_next = P_SETTLE;
            tick_count_next = 16'd0;
          end
        end else if (q_item.op == OP_TICK && phase == P_SETTLE) begin
          if (tick_inc >= reset_settle_ticks) begin
            bytes_n[0] = CmdSync;
            nbytes_n = 3'd1;
            phase_next = P_SYNC;
            tick_count_next = 16'd0;
          end
        end else if (waiting) begin
          if (q_item.op == OP_RX && db == AckByte) begin
            tick_count_next = 16'd0;
            unique case (phase)
              P_SYNC: begin
                if (second_reset && bytes_left == 25'd0) begin
                  bytes_n[0] = CmdGo;
                  bytes_n[1] = ~CmdGo;
                  phase_next = P_GOCMD;
                end else if (second_reset) begin
                  bytes_n[0] = CmdWrite;
                  bytes_n[1] = ~CmdWrite;
                  phase_next = P_WCMD;
                end else begin
                  bytes_n[0] = CmdErase;
                  bytes_n[1] = ~CmdErase;
                  phase_next = P_ERASE;
                end
                nbytes_n = 3'd2;
              end
              P_ERASE: begin
                bytes_n[0] = CmdGlobal;
                bytes_n[1] = ~CmdGlobal;
                nbytes_n = 3'd2;
                phase_next = P_GLOBAL;
              end
              P_UNPROT1: phase_next = P_UNPROT2;
              P_GLOBAL, P_UNPROT2: begin
                second_reset_next = 1'b1;
                phase_next = P_HOLD;
              end
              P_WCMD, P_GOCMD: begin
                bytes_n[0] = aa[31:24];
                bytes_n[1] = aa[23:16];
                bytes_n[2] = aa[15:8];
                bytes_n[3] = aa[7:0];
                bytes_n[4] = ab;
                nbytes_n = 3'd5;
                phase_next = (phase == P_WCMD) ? P_WADDR : P_GOADDR;
              end
              P_WADDR: begin
                if (bytes_left == 25'd0) begin
                  bytes_n[0] = CmdGo;
                  bytes_n[1] = ~CmdGo;
                  nbytes_n = 3'd2;
                  phase_next = P_GOCMD;
                end else begin
                  chunk_last_index_next = 8'(len - 25'd1);
                  chunk_position_next = 9'd0;
                  running_checksum_next = 8'(len - 25'd1);
                  bytes_n[0] = 8'(len - 25'd1);
                  nbytes_n = 3'd1;
                  phase_next = P_FEED;
                  want_n = 1'b1;
                end
              end
              P_WDATA: begin
                if (bytes_left == 25'd0) begin
                  bytes_n[0] = CmdGo;
                  bytes_n[1] = ~CmdGo;
                  phase_next = P_GOCMD;
                end else begin
                  bytes_n[0] = CmdWrite;
                  bytes_n[1] = ~CmdWrite;
                  phase_next = P_WCMD;
                end
                nbytes_n = 3'd2;
              end
              P_GOADDR: begin
                success_flag_next = 1'b1;
                done_n = 1'b1;
                phase_next = P_IDLE;
              end
              default: ;
            endcase
          end else if (q_item.op == OP_RX || tick_inc >= response_timeout_ticks) begin
            tick_count_next = 16'd0;
            if (phase == P_ERASE) begin
              unprotect_path_next = 1'b1;
              bytes_n[0] = CmdUnprot;
              bytes_n[1] = ~CmdUnprot;
              nbytes_n = 3'd2;
              phase_next = P_UNPROT1;
            end else begin
              success_flag_next = 1'b0;
              done_n = 1'b1;
              phase_next = P_IDLE;
            end
          end
        end else if (q_item.op == OP_TICK) begin
          tick_count_next = 16'd0;
        end
      end
      OP_IMAGE: begin
        if (phase == P_FEED) begin
          bytes_n[0] = db;
          nbytes_n = 3'd1;
          running_checksum_next = sum_new;
          chunk_position_next = pos_inc;
          image_offset_next = image_offset + 1'b1;
          bytes_left_next = bl_dec;
          write_address_next = write_address + 32'd1;
          if (pos_inc > {1'b0, chunk_last_index} || bl_dec == 25'd0) begin
            bytes_n[1] = sum_new;
            nbytes_n = 3'd2;
            phase_next = P_WDATA;
            tick_count_next = 16'd0;
          end else begin
            want_n = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= 25'd0;
      base_address <= 32'h0800_0000;
      response_timeout_ticks <= 16'd100;
      reset_hold_ticks <= 16'd100;
      reset_settle_ticks <= 16'd25;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegImageLength: image_length <= cfg_data[24:0];
        RegBaseAddress: base_address <= cfg_data;
        RegTimeout: response_timeout_ticks <= cfg_data[15:0];
        RegHold: reset_hold_ticks <= cfg_data[15:0];
        RegSettle: reset_settle_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      tick_count <= '0;
      bytes_left <= '0;
      write_address <= '0;
      image_offset <= '0;
      chunk_last_index <= '0;
      chunk_position <= '0;
      running_checksum <= '0;
      success_flag <= 1'b0;
      second_reset <= 1'b0;
      unprotect_path <= 1'b0;
      emitting <= 1'b0;
      sent <= 3'd0;
      nbytes <= 3'd0;
      want_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (q_valid && q_ready) begin
        phase <= phase_next;
        tick_count <= tick_count_next;
        bytes_left <= bytes_left_next;
        write_address <= write_address_next;
        image_offset <= image_offset_next;
        chunk_last_index <= chunk_last_index_next;
        chunk_position <= chunk_position_next;
        running_checksum <= running_checksum_next;
        success_flag <= success_flag_next;
        second_reset <= second_reset_next;
        unprotect_path <= unprotect_path_next;
        emitting <= 1'b1;
        sent <= 3'd0;
        nbytes <= nbytes_n;
        want_q <= want_n;
        done_q <= done_n;
      end else if (out_valid && out_ready) begin
        sent <= sent + 3'd1;
        if (fin) begin
          emitting <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      bytes_q <= bytes_n;
    end
  end

  assign nres = (nbytes == 3'd0) ? 3'd1 : nbytes;
  assign fin = (sent == nres - 3'd1);
  assign out_valid = emitting;
  assign out_last = fin;

  // tdata: tx_byte, power_on, tx_forced_low, need_image, image_index, busy_res, done_res,
  // success
  assign out_data = DataBits'({success_flag,
                               fin & done_q,
                               phase != P_IDLE,
                               (fin & want_q) ? image_offset : {IMAGE_INDEX_BITS{1'b0}},
                               fin & want_q,
                               (phase == P_HOLD) || (phase == P_SETTLE),
                               phase != P_HOLD,
                               (nbytes == 3'd0) ? 8'h00 : bytes_q[sent]});
  // tuser: tx_valid
  assign out_user[0] = (nbytes != 3'd0);

endmodule

// File: design/ubfs_checker.sv
module ubfs_protocol_checker
  import ubfs_pkg::*;
#(
  parameter int IMAGE_INDEX_BITS = ImageIndexBitsDefault,
  parameter int DATA_BITS = ((IMAGE_INDEX_BITS + 21) / 8) * 8
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [DATA_BITS-1:0] m_axis_tdata,
  input logic [0:0]           m_axis_tuser,
  input logic                 m_axis_tlast
);

  // need_image and done only on final beat
  a_need_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tlast) else $error("need_image not last");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[IMAGE_INDEX_BITS+12] |-> m_axis_tlast)
    else $error("done not last");
  // idle means power on and tx not forced low
  a_idle_power: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[IMAGE_INDEX_BITS+11] |-> m_axis_tdata[8] && !m_axis_tdata[9])
    else $error("idle power");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("beat changed while stalled");

endmodule

bind uart_bootloader_flash_sequencer ubfs_protocol_checker #(
  .IMAGE_INDEX_BITS(IMAGE_INDEX_BITS)
) u_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
